FILE: rtl/core/ecol_pkg.sv
package ecol_pkg;

    localparam int unsigned HEAVY_RATIO_DEF = 1000;
    localparam int RATIO_W = 16;

    localparam int IN_DATA_W  = 288;
    localparam int OUT_DATA_W = 128;

    localparam int MASS_W  = 16;
    localparam int VAL_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int M2_W    = 32;
    localparam int MT_W    = 33;
    localparam int NORM_W  = 14;
    localparam int LEAD_W  = 6;
    localparam int N2_W    = 29;
    localparam int FRAC_W  = 30;
    localparam int WGT_W   = 31;
    localparam int WNUM_W  = M2_W + FRAC_W;
    localparam int CNUM_W  = 63;
    localparam int CQ_W    = 38;
    localparam int SUM_W   = 40;
    localparam int LANES   = 4;

    localparam int LANE_V1X = 0;
    localparam int LANE_V1Y = 1;
    localparam int LANE_V2X = 2;
    localparam int LANE_V2Y = 3;

    // first_pos_x in the lowest bits
    typedef struct packed {
        logic [MASS_W-1:0]       second_mass;
        logic signed [VAL_W-1:0] second_vel_y;
        logic signed [VAL_W-1:0] second_vel_x;
        logic signed [VAL_W-1:0] second_pos_y;
        logic signed [VAL_W-1:0] second_pos_x;
        logic [MASS_W-1:0]       first_mass;
        logic signed [VAL_W-1:0] first_vel_y;
        logic signed [VAL_W-1:0] first_vel_x;
        logic signed [VAL_W-1:0] first_pos_y;
        logic signed [VAL_W-1:0] first_pos_x;
    } in_t;

    typedef struct packed {
        logic                     heavy;
        logic                     coinc;
        logic                     zero_mt;
        logic                     sx;
        logic                     sy;
        logic [NORM_W-1:0]        nx_mag;
        logic [NORM_W-1:0]        ny_mag;
        logic signed [DIFF_W-1:0] dvx;
        logic signed [DIFF_W-1:0] dvy;
        logic signed [DIFF_W-1:0] dv2x;
        logic signed [DIFF_W-1:0] dv2y;
        logic [LANES-1:0][VAL_W-1:0] vel;
        logic [M2_W-1:0]          m2;
        logic [MT_W-1:0]          mt;
    } front_t;

    typedef struct packed {
        logic                        heavy;
        logic                        coinc;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][VAL_W-1:0] vel;
    } pass_t;

    typedef struct packed {
        pass_t                        pass;
        logic [N2_W-1:0]              n2;
        logic [LANES-1:0][CNUM_W-1:0] mag;
    } proj_t;

    function automatic logic [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
        lo = -hi - SUM_W'(1);
        if (x > hi)
        begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
        if (x < lo)
        begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

FILE: rtl/core/elastic_collision_2d.sv
// Throughput: one transaction per cycle; the whole pipeline advances together and
// freezes while m_axis holds a result that is not taken.
// Most of the depth is in the two radix-4 dividers (weights 31 stages, corrections 32 stages).
// Reset: rst_n is asynchronous, active low, and clears all valid bits; results in flight are dropped.
module elastic_collision_2d #(
    parameter int unsigned HEAVY_RATIO = ecol_pkg::HEAVY_RATIO_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass
    input  logic [ecol_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // heavy_partner
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
    output logic [ecol_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // coincident_centres
    output logic                               m_axis_tuser
);

    logic                                                 en;
    logic                                                 front_vld;
    ecol_pkg::front_t                                     front;
    logic                                                 wdiv_vld;
    logic [0:0][ecol_pkg::WNUM_W-1:0]                     wdiv_num;
    logic [0:0][ecol_pkg::WNUM_W-1:0]                     wdiv_quo;
    logic [0:0][ecol_pkg::MT_W-1:0]                       wdiv_rem;
    ecol_pkg::front_t                                     wdiv_side;
    logic                                                 proj_vld;
    ecol_pkg::proj_t                                      proj;
    logic                                                 cdiv_vld;
    logic [ecol_pkg::LANES-1:0][ecol_pkg::CNUM_W-1:0]     cdiv_quo;
    ecol_pkg::pass_t                                      cdiv_side;

    logic                                                 out_valid_reg;
    logic [ecol_pkg::OUT_DATA_W-1:0]                      out_data_reg;
    logic [ecol_pkg::OUT_DATA_W-1:0]                      out_data_next;
    logic                                                 out_user_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    ecol_front #(
        .HEAVY_RATIO (HEAVY_RATIO)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (s_axis_tvalid),
        .heavy   (s_axis_tuser),
        .item    (ecol_pkg::in_t'(s_axis_tdata)),
        .vld_out (front_vld),
        .fo      (front)
    );

    assign wdiv_num[0] = {front.m2, {ecol_pkg::FRAC_W{1'b0}}};

    ecol_div #(
        .LANES  (1),
        .NUM_W  (ecol_pkg::WNUM_W),
        .DEN_W  (ecol_pkg::MT_W),
        .SIDE_W ($bits(ecol_pkg::front_t))
    ) u_wdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (front_vld),
        .num      (wdiv_num),
        .den      (front.mt),
        .side_in  (front),
        .vld_out  (wdiv_vld),
        .quo      (wdiv_quo),
        .rem      (wdiv_rem),
        .side_out (wdiv_side)
    );

    ecol_proj u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (wdiv_vld),
        .fi      (wdiv_side),
        .wq      (wdiv_quo[0]),
        .wr      (wdiv_rem[0]),
        .vld_out (proj_vld),
        .po      (proj)
    );

    ecol_div #(
        .LANES  (ecol_pkg::LANES),
        .NUM_W  (ecol_pkg::CNUM_W),
        .DEN_W  (ecol_pkg::N2_W),
        .SIDE_W ($bits(ecol_pkg::pass_t))
    ) u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (proj_vld),
        .num      (proj.mag),
        .den      (proj.n2),
        .side_in  (proj.pass),
        .vld_out  (cdiv_vld),
        .quo      (cdiv_quo),
        .rem      (),
        .side_out (cdiv_side)
    );

    // new velocity = v - corr, saturated; coincident centres and the heavy
    // partner's own velocity pass through
    always_comb
    begin : p_out
        logic signed [ecol_pkg::SUM_W-1:0] v;
        logic signed [ecol_pkg::SUM_W-1:0] c;
        logic signed [ecol_pkg::SUM_W-1:0] s;
        for (int l = 0; l < ecol_pkg::LANES; l++)
        begin
            v = ecol_pkg::SUM_W'($signed(cdiv_side.vel[l]));
            c = ecol_pkg::SUM_W'(cdiv_quo[l][ecol_pkg::CQ_W-1:0]);
            s = cdiv_side.neg[l] ? v + c : v - c;
            if (cdiv_side.coinc ||
                (cdiv_side.heavy && (l == ecol_pkg::LANE_V2X || l == ecol_pkg::LANE_V2Y)))
            begin
                out_data_next[l*ecol_pkg::VAL_W +: ecol_pkg::VAL_W] = cdiv_side.vel[l];
            end
            else
            begin
                out_data_next[l*ecol_pkg::VAL_W +: ecol_pkg::VAL_W] = ecol_pkg::sat32(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cdiv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= cdiv_side.coinc;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: rtl/core/ecol_div.sv
module ecol_div #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 62,
    parameter int DEN_W  = 33,
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         vld_in,
    input  logic [LANES-1:0][NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]             den,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         vld_out,
    output logic [LANES-1:0][NUM_W-1:0]  quo,
    output logic [LANES-1:0][DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int STEPS  = 2;
    localparam int STAGES = (NUM_W + STEPS - 1) / STEPS;
    localparam int NUM_P  = STAGES * STEPS;

    // dividend bits leave at the top, quotient bits enter at the bottom
    logic [LANES-1:0][NUM_P-1:0] acc_reg  [STAGES];
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [STAGES];
    logic [DEN_W-1:0]            den_reg  [STAGES];
    logic [SIDE_W-1:0]           side_reg [STAGES];
    logic                        vld_reg  [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [LANES-1:0][NUM_P-1:0] acc_in;
        logic [LANES-1:0][NUM_P-1:0] acc_next;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][DEN_W-1:0] rem_next;
        logic [DEN_W-1:0]            den_in;
        logic [SIDE_W-1:0]           side_s;
        logic                        vld_s;

        if (s == 0)
        begin : g_head
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    acc_in[l] = NUM_P'(num[l]);
                    rem_in[l] = '0;
                end
            end
            assign den_in = den;
            assign side_s = side_in;
            assign vld_s  = vld_in;
        end
        else
        begin : g_body
            assign acc_in = acc_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign side_s = side_reg[s-1];
            assign vld_s  = vld_reg[s-1];
        end

        always_comb
        begin : p_step
            logic [NUM_P-1:0] a;
            logic [DEN_W-1:0] r;
            logic [DEN_W:0]   t;
            for (int l = 0; l < LANES; l++)
            begin
                a = acc_in[l];
                r = rem_in[l];
                for (int k = 0; k < STEPS; k++)
                begin
                    t = {r, a[NUM_P-1]};
                    a = {a[NUM_P-2:0], 1'b0};
                    if (t >= {1'b0, den_in})
                    begin
                        t    = t - {1'b0, den_in};
                        a[0] = 1'b1;
                    end
                    r = t[DEN_W-1:0];
                end
                acc_next[l] = a;
                rem_next[l] = r;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_s;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s]  <= acc_next;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_s;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = acc_reg[STAGES-1][l][NUM_W-1:0];
        end
    end

    assign rem      = rem_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];
    assign vld_out  = vld_reg[STAGES-1];

endmodule

FILE: rtl/core/ecol_front.sv
module ecol_front #(
    parameter int unsigned HEAVY_RATIO = ecol_pkg::HEAVY_RATIO_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  logic             heavy,
    input  ecol_pkg::in_t    item,
    output logic             vld_out,
    output ecol_pkg::front_t fo
);

    localparam logic [ecol_pkg::RATIO_W-1:0] RATIO = HEAVY_RATIO[ecol_pkg::RATIO_W-1:0];
    localparam int NSTG = 5;

    typedef struct packed {
        logic                               heavy;
        logic signed [ecol_pkg::DIFF_W-1:0] dx;
        logic signed [ecol_pkg::DIFF_W-1:0] dy;
        logic signed [ecol_pkg::DIFF_W-1:0] dvx;
        logic signed [ecol_pkg::DIFF_W-1:0] dvy;
        logic signed [ecol_pkg::DIFF_W-1:0] dv2x;
        logic signed [ecol_pkg::DIFF_W-1:0] dv2y;
        logic [ecol_pkg::LANES-1:0][ecol_pkg::VAL_W-1:0] vel;
        logic [ecol_pkg::M2_W-1:0]          m2;
        logic [ecol_pkg::MASS_W-1:0]        m1;
    } s1_t;

    typedef struct packed {
        logic                               heavy;
        logic                               coinc;
        logic                               zero_mt;
        logic                               sx;
        logic                               sy;
        logic [ecol_pkg::DIFF_W-1:0]        ax;
        logic [ecol_pkg::DIFF_W-1:0]        ay;
        logic signed [ecol_pkg::DIFF_W-1:0] dvx;
        logic signed [ecol_pkg::DIFF_W-1:0] dvy;
        logic signed [ecol_pkg::DIFF_W-1:0] dv2x;
        logic signed [ecol_pkg::DIFF_W-1:0] dv2y;
        logic [ecol_pkg::LANES-1:0][ecol_pkg::VAL_W-1:0] vel;
        logic [ecol_pkg::M2_W-1:0]          m2;
        logic [ecol_pkg::MT_W-1:0]          mt;
    } s2_t;

    typedef struct packed {
        s2_t                         b;
        logic [ecol_pkg::DIFF_W-1:0] amax;
    } s3_t;

    typedef struct packed {
        s2_t                         b;
        logic [ecol_pkg::LEAD_W-1:0] lp;
    } s4_t;

    s1_t              s1_next, s1_reg;
    s2_t              s2_next, s2_reg;
    s3_t              s3_next, s3_reg;
    s4_t              s4_next, s4_reg;
    ecol_pkg::front_t s5_next, s5_reg;
    logic [NSTG-1:0]  vld_reg;

    always_comb
    begin
        s1_next.heavy = heavy;
        s1_next.dx    = ecol_pkg::DIFF_W'(item.second_pos_x) - ecol_pkg::DIFF_W'(item.first_pos_x);
        s1_next.dy    = ecol_pkg::DIFF_W'(item.second_pos_y) - ecol_pkg::DIFF_W'(item.first_pos_y);
        s1_next.dvx   = ecol_pkg::DIFF_W'(item.first_vel_x) - ecol_pkg::DIFF_W'(item.second_vel_x);
        s1_next.dvy   = ecol_pkg::DIFF_W'(item.first_vel_y) - ecol_pkg::DIFF_W'(item.second_vel_y);
        s1_next.dv2x  = ecol_pkg::DIFF_W'(item.second_vel_x) - ecol_pkg::DIFF_W'(item.first_vel_x);
        s1_next.dv2y  = ecol_pkg::DIFF_W'(item.second_vel_y) - ecol_pkg::DIFF_W'(item.first_vel_y);
        s1_next.vel[ecol_pkg::LANE_V1X] = item.first_vel_x;
        s1_next.vel[ecol_pkg::LANE_V1Y] = item.first_vel_y;
        s1_next.vel[ecol_pkg::LANE_V2X] = item.second_vel_x;
        s1_next.vel[ecol_pkg::LANE_V2Y] = item.second_vel_y;
        s1_next.m1    = item.first_mass;
        s1_next.m2    = heavy ? ecol_pkg::M2_W'(item.first_mass) * ecol_pkg::M2_W'(RATIO)
                              : ecol_pkg::M2_W'(item.second_mass);
    end

    always_comb
    begin
        s2_next.heavy   = s1_reg.heavy;
        s2_next.coinc   = (s1_reg.dx == '0) && (s1_reg.dy == '0);
        s2_next.zero_mt = (s1_reg.m1 == '0) && (s1_reg.m2 == '0);
        s2_next.sx      = s1_reg.dx[ecol_pkg::DIFF_W-1];
        s2_next.sy      = s1_reg.dy[ecol_pkg::DIFF_W-1];
        s2_next.ax      = s1_reg.dx[ecol_pkg::DIFF_W-1] ? -s1_reg.dx : s1_reg.dx;
        s2_next.ay      = s1_reg.dy[ecol_pkg::DIFF_W-1] ? -s1_reg.dy : s1_reg.dy;
        s2_next.dvx     = s1_reg.dvx;
        s2_next.dvy     = s1_reg.dvy;
        s2_next.dv2x    = s1_reg.dv2x;
        s2_next.dv2y    = s1_reg.dv2y;
        s2_next.vel     = s1_reg.vel;
        s2_next.m2      = s1_reg.m2;
        s2_next.mt      = ecol_pkg::MT_W'(s1_reg.m1) + ecol_pkg::MT_W'(s1_reg.m2);
    end

    always_comb
    begin
        s3_next.b    = s2_reg;
        s3_next.amax = (s2_reg.ax > s2_reg.ay) ? s2_reg.ax : s2_reg.ay;
    end

    // leading one of the larger magnitude
    always_comb
    begin
        s4_next.b  = s3_reg.b;
        s4_next.lp = '0;
        for (int i = 0; i < ecol_pkg::DIFF_W; i++)
        begin
            if (s3_reg.amax[i])
            begin
                s4_next.lp = ecol_pkg::LEAD_W'(i);
            end
        end
    end

    // bring the larger magnitude into [2^13, 2^14)
    always_comb
    begin : p_norm
        logic [ecol_pkg::LEAD_W-1:0] sh;
        if (s4_reg.lp >= ecol_pkg::LEAD_W'(ecol_pkg::NORM_W))
        begin
            sh = s4_reg.lp - ecol_pkg::LEAD_W'(ecol_pkg::NORM_W - 1);
            s5_next.nx_mag = ecol_pkg::NORM_W'(s4_reg.b.ax >> sh);
            s5_next.ny_mag = ecol_pkg::NORM_W'(s4_reg.b.ay >> sh);
        end
        else
        begin
            sh = ecol_pkg::LEAD_W'(ecol_pkg::NORM_W - 1) - s4_reg.lp;
            s5_next.nx_mag = ecol_pkg::NORM_W'(s4_reg.b.ax << sh);
            s5_next.ny_mag = ecol_pkg::NORM_W'(s4_reg.b.ay << sh);
        end
        s5_next.heavy   = s4_reg.b.heavy;
        s5_next.coinc   = s4_reg.b.coinc;
        s5_next.zero_mt = s4_reg.b.zero_mt;
        s5_next.sx      = s4_reg.b.sx;
        s5_next.sy      = s4_reg.b.sy;
        s5_next.dvx     = s4_reg.b.dvx;
        s5_next.dvy     = s4_reg.b.dvy;
        s5_next.dv2x    = s4_reg.b.dv2x;
        s5_next.dv2y    = s4_reg.b.dv2y;
        s5_next.vel     = s4_reg.b.vel;
        s5_next.m2      = s4_reg.b.m2;
        s5_next.mt      = s4_reg.b.mt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign vld_out = vld_reg[NSTG-1];
    assign fo      = s5_reg;

endmodule

FILE: rtl/core/ecol_proj.sv
module ecol_proj (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          vld_in,
    input  ecol_pkg::front_t              fi,
    input  logic [ecol_pkg::WNUM_W-1:0]   wq,
    input  logic [ecol_pkg::MT_W-1:0]     wr,
    output logic                          vld_out,
    output ecol_pkg::proj_t               po
);

    localparam int NSTG  = 7;
    localparam int NS_W  = ecol_pkg::NORM_W + 1;
    localparam int PR_W  = ecol_pkg::WGT_W + 1 + ecol_pkg::DIFF_W;
    localparam int R_W   = ecol_pkg::DIFF_W + 1;
    localparam int Q_W   = R_W + NS_W;
    localparam int DOT_W = Q_W + 1;
    localparam int E_W   = DOT_W + NS_W;

    typedef struct packed {
        ecol_pkg::pass_t                    pass;
        logic signed [NS_W-1:0]             nx;
        logic signed [NS_W-1:0]             ny;
        logic [ecol_pkg::N2_W-1:0]          n2;
        logic [ecol_pkg::WGT_W-1:0]         w1;
        logic [ecol_pkg::WGT_W-1:0]         w2;
        logic signed [ecol_pkg::DIFF_W-1:0] dvx;
        logic signed [ecol_pkg::DIFF_W-1:0] dvy;
        logic signed [ecol_pkg::DIFF_W-1:0] dv2x;
        logic signed [ecol_pkg::DIFF_W-1:0] dv2y;
    } t1_t;

    typedef struct packed {
        ecol_pkg::pass_t           pass;
        logic signed [NS_W-1:0]    nx;
        logic signed [NS_W-1:0]    ny;
        logic [ecol_pkg::N2_W-1:0] n2;
        logic signed [PR_W-1:0]    p1x;
        logic signed [PR_W-1:0]    p1y;
        logic signed [PR_W-1:0]    p2x;
        logic signed [PR_W-1:0]    p2y;
    } t2_t;

    typedef struct packed {
        ecol_pkg::pass_t           pass;
        logic signed [NS_W-1:0]    nx;
        logic signed [NS_W-1:0]    ny;
        logic [ecol_pkg::N2_W-1:0] n2;
        logic signed [R_W-1:0]     r1x;
        logic signed [R_W-1:0]     r1y;
        logic signed [R_W-1:0]     r2x;
        logic signed [R_W-1:0]     r2y;
    } t3_t;

    typedef struct packed {
        ecol_pkg::pass_t           pass;
        logic signed [NS_W-1:0]    nx;
        logic signed [NS_W-1:0]    ny;
        logic [ecol_pkg::N2_W-1:0] n2;
        logic signed [Q_W-1:0]     q1x;
        logic signed [Q_W-1:0]     q1y;
        logic signed [Q_W-1:0]     q2x;
        logic signed [Q_W-1:0]     q2y;
    } t4_t;

    typedef struct packed {
        ecol_pkg::pass_t           pass;
        logic signed [NS_W-1:0]    nx;
        logic signed [NS_W-1:0]    ny;
        logic [ecol_pkg::N2_W-1:0] n2;
        logic signed [DOT_W-1:0]   dot1;
        logic signed [DOT_W-1:0]   dot2;
    } t5_t;

    typedef struct packed {
        ecol_pkg::pass_t                         pass;
        logic [ecol_pkg::N2_W-1:0]               n2;
        logic [ecol_pkg::LANES-1:0][E_W-1:0]     e;
    } t6_t;

    // Q1.30 weight times Q16.16 difference back to Q16.16, truncated toward zero
    function automatic logic signed [R_W-1:0] trunc_frac(input logic signed [PR_W-1:0] p);
        logic signed [PR_W-1:0] b;
        b = p + (p[PR_W-1] ? PR_W'({ecol_pkg::FRAC_W{1'b1}}) : PR_W'(0));
        return R_W'(b >>> ecol_pkg::FRAC_W);
    endfunction

    t1_t             t1_next, t1_reg;
    t2_t             t2_next, t2_reg;
    t3_t             t3_next, t3_reg;
    t4_t             t4_next, t4_reg;
    t5_t             t5_next, t5_reg;
    t6_t             t6_next, t6_reg;
    ecol_pkg::proj_t t7_next, t7_reg;
    logic [NSTG-1:0] vld_reg;

    // w1 follows from w2: the two remainders sum to zero or to the total mass
    always_comb
    begin : p_wgt
        logic [ecol_pkg::WGT_W-1:0] w2;
        logic [ecol_pkg::WGT_W-1:0] one;
        w2  = wq[ecol_pkg::WGT_W-1:0];
        one = ecol_pkg::WGT_W'(1) << ecol_pkg::FRAC_W;
        t1_next.pass.heavy = fi.heavy;
        t1_next.pass.coinc = fi.coinc;
        t1_next.pass.neg   = '0;
        t1_next.pass.vel   = fi.vel;
        t1_next.nx = fi.sx ? -NS_W'(fi.nx_mag) : NS_W'(fi.nx_mag);
        t1_next.ny = fi.sy ? -NS_W'(fi.ny_mag) : NS_W'(fi.ny_mag);
        t1_next.n2 = ecol_pkg::N2_W'(fi.nx_mag) * ecol_pkg::N2_W'(fi.nx_mag)
                   + ecol_pkg::N2_W'(fi.ny_mag) * ecol_pkg::N2_W'(fi.ny_mag);
        if (fi.zero_mt)
        begin
            t1_next.w1 = one >> 1;
            t1_next.w2 = one >> 1;
        end
        else
        begin
            t1_next.w2 = w2;
            t1_next.w1 = one - w2 - ecol_pkg::WGT_W'(wr != '0);
        end
        t1_next.dvx  = fi.dvx;
        t1_next.dvy  = fi.dvy;
        t1_next.dv2x = fi.dv2x;
        t1_next.dv2y = fi.dv2y;
    end

    always_comb
    begin
        t2_next.pass = t1_reg.pass;
        t2_next.nx   = t1_reg.nx;
        t2_next.ny   = t1_reg.ny;
        t2_next.n2   = t1_reg.n2;
        t2_next.p1x  = $signed({1'b0, t1_reg.w2}) * $signed(t1_reg.dvx);
        t2_next.p1y  = $signed({1'b0, t1_reg.w2}) * $signed(t1_reg.dvy);
        t2_next.p2x  = $signed({1'b0, t1_reg.w1}) * $signed(t1_reg.dv2x);
        t2_next.p2y  = $signed({1'b0, t1_reg.w1}) * $signed(t1_reg.dv2y);
    end

    always_comb
    begin
        t3_next.pass = t2_reg.pass;
        t3_next.nx   = t2_reg.nx;
        t3_next.ny   = t2_reg.ny;
        t3_next.n2   = t2_reg.n2;
        t3_next.r1x  = trunc_frac(t2_reg.p1x);
        t3_next.r1y  = trunc_frac(t2_reg.p1y);
        t3_next.r2x  = trunc_frac(t2_reg.p2x);
        t3_next.r2y  = trunc_frac(t2_reg.p2y);
    end

    always_comb
    begin
        t4_next.pass = t3_reg.pass;
        t4_next.nx   = t3_reg.nx;
        t4_next.ny   = t3_reg.ny;
        t4_next.n2   = t3_reg.n2;
        t4_next.q1x  = $signed(t3_reg.r1x) * $signed(t3_reg.nx);
        t4_next.q1y  = $signed(t3_reg.r1y) * $signed(t3_reg.ny);
        t4_next.q2x  = $signed(t3_reg.r2x) * $signed(t3_reg.nx);
        t4_next.q2y  = $signed(t3_reg.r2y) * $signed(t3_reg.ny);
    end

    always_comb
    begin
        t5_next.pass = t4_reg.pass;
        t5_next.nx   = t4_reg.nx;
        t5_next.ny   = t4_reg.ny;
        t5_next.n2   = t4_reg.n2;
        t5_next.dot1 = DOT_W'($signed(t4_reg.q1x)) + DOT_W'($signed(t4_reg.q1y));
        t5_next.dot2 = DOT_W'($signed(t4_reg.q2x)) + DOT_W'($signed(t4_reg.q2y));
    end

    always_comb
    begin
        t6_next.pass = t5_reg.pass;
        t6_next.n2   = t5_reg.n2;
        t6_next.e[ecol_pkg::LANE_V1X] = E_W'($signed(t5_reg.dot1)) * E_W'($signed(t5_reg.nx));
        t6_next.e[ecol_pkg::LANE_V1Y] = E_W'($signed(t5_reg.dot1)) * E_W'($signed(t5_reg.ny));
        t6_next.e[ecol_pkg::LANE_V2X] = E_W'($signed(t5_reg.dot2)) * E_W'($signed(t5_reg.nx));
        t6_next.e[ecol_pkg::LANE_V2Y] = E_W'($signed(t5_reg.dot2)) * E_W'($signed(t5_reg.ny));
    end

    // sign and doubled magnitude for the divider
    always_comb
    begin : p_mag
        logic [E_W-1:0] a;
        t7_next.pass = t6_reg.pass;
        t7_next.n2   = t6_reg.n2;
        for (int l = 0; l < ecol_pkg::LANES; l++)
        begin
            a = t6_reg.e[l][E_W-1] ? -t6_reg.e[l] : t6_reg.e[l];
            t7_next.pass.neg[l] = t6_reg.e[l][E_W-1];
            t7_next.mag[l]      = {a[ecol_pkg::CNUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
            t4_reg <= t4_next;
            t5_reg <= t5_next;
            t6_reg <= t6_next;
            t7_reg <= t7_next;
        end
    end

    assign vld_out = vld_reg[NSTG-1];
    assign po      = t7_reg;

endmodule

FILE: rtl/core/ecol_chk.sv
module ecol_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ecol_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ecol_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output stall");

    a_in_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind elastic_collision_2d ecol_chk u_ecol_chk (.*);

FILE: verif/tb_elastic_collision_2d.sv
module tb_elastic_collision_2d;

    localparam int HEAVY = 1000;
    localparam int N_RAND = 1000;
    localparam int DRAIN = 120;

    typedef struct packed {
        logic [31:0] v1x;
        logic [31:0] v1y;
        logic [31:0] v2x;
        logic [31:0] v2y;
        logic        coinc;
    } vel_out_t;

    typedef struct {
        logic          heavy;
        ecol_pkg::in_t d;
        logic          known;
        vel_out_t      res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [ecol_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [ecol_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    vel_out_t pending_vel[$];
    int errors;
    bit stim_done;

    elastic_collision_2d u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic longint unsigned abs64(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint trunc_shr(longint x, int s);
        longint unsigned m;
        m = abs64(x) >> s;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        if (x < -64'sd2147483648)
        begin
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    function automatic vel_out_t collide(logic heavy, ecol_pkg::in_t d);
        vel_out_t r;
        longint p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, dx, dy, nx, ny, n2;
        longint dvx, dvy, r1x, r1y, r2x, r2y, dot1, dot2;
        longint unsigned ax, ay, a, m1, m2, mt, w1, w2;
        p1x = longint'(signed'(d.first_pos_x));
        p1y = longint'(signed'(d.first_pos_y));
        v1x = longint'(signed'(d.first_vel_x));
        v1y = longint'(signed'(d.first_vel_y));
        p2x = longint'(signed'(d.second_pos_x));
        p2y = longint'(signed'(d.second_pos_y));
        v2x = longint'(signed'(d.second_vel_x));
        v2y = longint'(signed'(d.second_vel_y));
        m1 = d.first_mass;
        m2 = heavy ? m1 * HEAVY : d.second_mass;
        r = '{d.first_vel_x, d.first_vel_y, d.second_vel_x, d.second_vel_y, 1'b0};
        dx = p2x - p1x;
        dy = p2y - p1y;
        if (dx == 0 && dy == 0)
        begin
            r.coinc = 1'b1;
            return r;
        end
        ax = abs64(dx);
        ay = abs64(dy);
        a = (ax > ay) ? ax : ay;
        while (a >= (64'd1 << 14))
        begin
            a >>= 1; ax >>= 1; ay >>= 1;
        end
        while (a < (64'd1 << 13))
        begin
            a <<= 1; ax <<= 1; ay <<= 1;
        end
        nx = (dx < 0) ? -longint'(ax) : longint'(ax);
        ny = (dy < 0) ? -longint'(ay) : longint'(ay);
        n2 = nx * nx + ny * ny;
        mt = m1 + m2;
        if (mt == 0)
        begin
            w1 = 64'd1 << 29;
            w2 = 64'd1 << 29;
        end
        else
        begin
            w1 = (m1 << 30) / mt;
            w2 = (m2 << 30) / mt;
        end
        dvx = v1x - v2x;
        dvy = v1y - v2y;
        r1x = trunc_shr(longint'(w2) * dvx, 30);
        r1y = trunc_shr(longint'(w2) * dvy, 30);
        dot1 = r1x * nx + r1y * ny;
        r.v1x = clamp32(v1x - (2 * dot1 * nx) / n2);
        r.v1y = clamp32(v1y - (2 * dot1 * ny) / n2);
        if (!heavy)
        begin
            r2x = -trunc_shr(longint'(w1) * dvx, 30);
            r2y = -trunc_shr(longint'(w1) * dvy, 30);
            dot2 = r2x * nx + r2y * ny;
            r.v2x = clamp32(v2x - (2 * dot2 * nx) / n2);
            r.v2y = clamp32(v2y - (2 * dot2 * ny) / n2);
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_word(int style);
        case (style)
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            default: return ($urandom_range(0, 1)) ? 32'h7fffffff - $urandom_range(0, 3)
                                                   : 32'h80000000 + $urandom_range(0, 3);
        endcase
    endfunction

    function automatic ecol_pkg::in_t rand_pair();
        ecol_pkg::in_t d;
        int sp, sv;
        sp = $urandom_range(0, 3);
        sv = $urandom_range(0, 3);
        d.first_pos_x = rand_word(sp);
        d.first_pos_y = rand_word(sp);
        d.second_pos_x = rand_word(sp);
        d.second_pos_y = rand_word(sp);
        if ($urandom_range(0, 19) == 0)
        begin
            d.second_pos_x = d.first_pos_x;
            d.second_pos_y = d.first_pos_y;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            d.second_pos_y = d.first_pos_y;
        end
        d.first_vel_x = rand_word(sv);
        d.first_vel_y = rand_word(sv);
        d.second_vel_x = rand_word(sv);
        d.second_vel_y = rand_word(sv);
        d.first_mass = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 50));
        d.second_mass = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 50));
        if ($urandom_range(0, 49) == 0)
        begin
            d.first_mass = '0;
            d.second_mass = '0;
        end
        return d;
    endfunction

    function automatic ecol_pkg::in_t mk(logic [31:0] p1x, logic [31:0] p1y, logic [31:0] v1x,
                                         logic [31:0] v1y, logic [15:0] m1, logic [31:0] p2x,
                                         logic [31:0] p2y, logic [31:0] v2x, logic [31:0] v2y,
                                         logic [15:0] m2);
        ecol_pkg::in_t d;
        d.first_pos_x = p1x; d.first_pos_y = p1y;
        d.first_vel_x = v1x; d.first_vel_y = v1y; d.first_mass = m1;
        d.second_pos_x = p2x; d.second_pos_y = p2y;
        d.second_vel_x = v2x; d.second_vel_y = v2y; d.second_mass = m2;
        return d;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, the next call or the caller lowers it
    task automatic send_pair(logic heavy, ecol_pkg::in_t d, logic known, vel_out_t res);
        vel_out_t exp_v;
        int n;
        n = $urandom_range(0, 17);
        if (n != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        exp_v = collide(heavy, d);
        if (known && exp_v != res)
        begin
            $error("table row disagrees with predictor: table %h predictor %h", res, exp_v);
            errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= heavy;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        pending_vel.push_back(known ? res : exp_v);
        @(negedge clk);
    endtask

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        ecol_pkg::in_t d;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        errors = 0;
        stim_done = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // coincident centres pass everything through
        d = mk(32'h00010000, 32'h00020000, 32'h7fffffff, 32'h80000000, 16'd1,
               32'h00010000, 32'h00020000, 32'h12345678, 32'hedcba987, 16'd65535);
        rows.push_back('{1'b0, d, 1'b1, '{32'h7fffffff, 32'h80000000, 32'h12345678,
                                         32'hedcba987, 1'b1}});
        rows.push_back('{1'b1, d, 1'b1, '{32'h7fffffff, 32'h80000000, 32'h12345678,
                                         32'hedcba987, 1'b1}});
        // equal velocities: no change
        d = mk(0, 0, 32'h00010000, 0, 16'd5, 32'h00010000, 0, 32'h00010000, 0, 16'd5);
        rows.push_back('{1'b0, d, 1'b1, '{32'h00010000, 0, 32'h00010000, 0, 1'b0}});
        rows.push_back('{1'b1, d, 1'b0, '0});
        // extremes
        d = mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'd65535,
               32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 16'd65535);
        rows.push_back('{1'b0, d, 1'b0, '0});
        rows.push_back('{1'b1, d, 1'b0, '0});
        d = mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'd1,
               32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'd65535);
        rows.push_back('{1'b0, d, 1'b0, '0});
        d = mk(0, 0, 32'h00020000, 32'hffff0000, 16'd65535, 1, 0, 0, 0, 16'd1);
        rows.push_back('{1'b0, d, 1'b0, '0});
        rows.push_back('{1'b1, d, 1'b0, '0});
        d = mk(0, 0, 32'h00020000, 32'hffff0000, 16'd1, 0, 32'hffffffff, 0, 0, 16'd65535);
        rows.push_back('{1'b0, d, 1'b0, '0});
        // zero masses, zero total mass
        d = mk(0, 0, 32'h00010000, 0, 16'd0, 32'h00100000, 0, 32'hffff0000, 0, 16'd0);
        rows.push_back('{1'b0, d, 1'b0, '0});
        rows.push_back('{1'b1, d, 1'b0, '0});
        d = mk(0, 0, 32'h00010000, 0, 16'd0, 32'h00100000, 32'h00300000, 0, 0, 16'd7);
        rows.push_back('{1'b0, d, 1'b0, '0});
        d = mk(0, 0, 32'h00010000, 32'h00050000, 16'd9, 32'h00002000, 32'h00003fff,
               0, 0, 16'd0);
        rows.push_back('{1'b0, d, 1'b0, '0});

        foreach (rows[i])
        begin
            row = rows[i];
            send_pair(row.heavy, row.d, row.known, row.res);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_vel.size() != 0)
        begin
            @(negedge clk);
        end
        for (int i = 0; i < N_RAND; i++)
        begin
            send_pair(($urandom_range(0, 2) == 0), rand_pair(), 1'b0, '0);
            if (i == N_RAND / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_vel.size() != 0)
                begin
                    @(negedge clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(0, 17);
            if (n != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        vel_out_t got;
        vel_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                    m_axis_tdata[127:96], m_axis_tuser};
            if (pending_vel.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                want = pending_vel.pop_front();
                if (got.v1x !== want.v1x)
                begin
                    $error("new_first_vel_x expected %h actual %h", want.v1x, got.v1x);
                    errors++;
                end
                if (got.v1y !== want.v1y)
                begin
                    $error("new_first_vel_y expected %h actual %h", want.v1y, got.v1y);
                    errors++;
                end
                if (got.v2x !== want.v2x)
                begin
                    $error("new_second_vel_x expected %h actual %h", want.v2x, got.v2x);
                    errors++;
                end
                if (got.v2y !== want.v2y)
                begin
                    $error("new_second_vel_y expected %h actual %h", want.v2y, got.v2y);
                    errors++;
                end
                if (got.coinc !== want.coinc)
                begin
                    $error("coincident_centres expected %b actual %b", want.coinc, got.coinc);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (stim_done);
        while (pending_vel.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ecol_pkg.sv
rtl/core/ecol_div.sv
rtl/core/ecol_front.sv
rtl/core/ecol_proj.sv
rtl/core/elastic_collision_2d.sv
rtl/core/ecol_chk.sv
verif/tb_elastic_collision_2d.sv
